// ----- rtl/assert_macros.svh -----
// Assertion macros used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/tas_pkg.sv -----
package tas_pkg;
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] KIND_HOLD = 2'd0;
  localparam logic [1:0] KIND_HAMMER = 2'd1;
  localparam logic [1:0] KIND_CONTACT = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;
  // What a cell does during its turn.
  localparam logic [1:0] PASS_MATCH = 2'd0;
  localparam logic [1:0] PASS_CANCEL = 2'd1;
  localparam logic [1:0] PASS_TICK = 2'd2;
  localparam logic [1:0] PASS_WRITE = 2'd3;
  localparam int MAX_RESULTS = 8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  action_kind;
    logic [7:0]  target_id;
    logic [15:0] duration;
    logic [15:0] interval;
    logic [31:0] now_time;
    logic        cancel_contact_domain;
    logic        cancel_key_domain;
    logic        match_target;
    logic [3:0]  event_limit;
  } cmd_t;

  typedef struct packed {
    logic        event_valid;
    logic [1:0]  event_kind;
    logic [7:0]  event_target;
    logic        event_pressed;
    logic        accepted;
    logic [3:0]  active_entries;
    logic        key_active;
    logic        last;
  } res_t;

  // Token passed along the row of cells during a scan.
  typedef struct packed {
    logic       go;
    logic       found_match;
    logic       found_free;
    logic [3:0] events;
    logic       stopped;
  } tok_t;

  // What a cell reports to the controller during its turn.
  typedef struct packed {
    logic       active;
    logic       match;
    logic       key_hit;
    logic       emit;
    logic [1:0] kind;
    logic [7:0] target;
    logic       pressed;
  } cell_rpt_t;

  function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return ~d[31];
  endfunction
endpackage

// ----- rtl/tas_if.sv -----
interface tas_cmd_if;
  logic valid;
  logic ready;
  tas_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tas_res_if;
  logic valid;
  logic ready;
  tas_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tas_cell.sv -----
// One table entry. It acts only in its turn, when the scan index reaches it.
module tas_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           turn,
  input  logic [1:0]     pass,
  input  tas_pkg::cmd_t  cmd,
  input  logic [3:0]     lim,
  input  logic           sel,
  input  tas_pkg::tok_t  tok_in,
  output tas_pkg::tok_t  tok_out,
  output tas_pkg::cell_rpt_t rpt
);
  logic        active, pressed;
  logic [1:0]  kind;
  logic [7:0]  target;
  logic [31:0] end_time, next_toggle;
  logic [14:0] half;
  logic [31:0] adv;
  logic        is_c, dom, hit, end_r, tog_r, stop;
  logic [14:0] half_new;

  always_comb begin
    is_c = (kind == tas_pkg::KIND_CONTACT);
    hit = active && (is_c == (cmd.action_kind == tas_pkg::KIND_CONTACT))
          && (target == cmd.target_id);
    dom = is_c ? cmd.cancel_contact_domain : cmd.cancel_key_domain;
    end_r = tas_pkg::reached(cmd.now_time, end_time);
    tog_r = (kind == tas_pkg::KIND_HAMMER) && tas_pkg::reached(cmd.now_time, next_toggle);
    adv = next_toggle + {17'd0, half};
    stop = tok_in.stopped || (active && tok_in.events >= lim);
    half_new = (cmd.interval[15:1] == 15'd0) ? 15'd1 : cmd.interval[15:1];
    tok_out = tok_in;
    rpt = '0;
    rpt.active = active;
    rpt.kind = kind;
    rpt.target = target;
    rpt.key_hit = active && !is_c && target == cmd.target_id;
    if (pass == tas_pkg::PASS_MATCH) begin
      rpt.match = hit;
      tok_out.found_match = tok_in.found_match | hit;
      tok_out.found_free = tok_in.found_free | ~active;
    end else if (pass == tas_pkg::PASS_CANCEL) begin
      if (active && dom && (!cmd.match_target || target == cmd.target_id) && pressed
          && tok_in.events < lim) begin
        rpt.emit = 1'b1;
        tok_out.events = tok_in.events + 4'd1;
      end
    end else begin
      tok_out.stopped = stop;
      if (!stop && active && (end_r ? pressed : tog_r)) begin
        rpt.emit = 1'b1;
        rpt.pressed = end_r ? 1'b0 : ~pressed;
        tok_out.events = tok_in.events + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pressed <= 1'b0;
    end else if (turn) begin
      if (pass == tas_pkg::PASS_WRITE && sel) begin
        active <= 1'b1;
        pressed <= 1'b1;
        kind <= cmd.action_kind;
        target <= cmd.target_id;
        end_time <= cmd.now_time + {16'd0, cmd.duration};
        half <= (cmd.action_kind == tas_pkg::KIND_HAMMER) ? half_new : 15'd0;
        next_toggle <= cmd.now_time +
          {17'd0, (cmd.action_kind == tas_pkg::KIND_HAMMER) ? half_new : 15'd0};
      end else if (pass == tas_pkg::PASS_CANCEL) begin
        if (active && dom && (!cmd.match_target || target == cmd.target_id)) begin
          active <= 1'b0;
          pressed <= 1'b0;
        end
      end else if (pass == tas_pkg::PASS_TICK && !stop && active) begin
        if (end_r) begin
          active <= 1'b0;
          pressed <= 1'b0;
        end else if (tog_r) begin
          pressed <= ~pressed;
          next_toggle <= tas_pkg::reached(cmd.now_time, adv)
                         ? cmd.now_time + {17'd0, half} : adv;
        end
      end
    end
  end
endmodule

// ----- rtl/timed_action_scheduler.sv -----
// Timed action scheduler: a row of NUM_ENTRIES cells walked one cell per cycle.
// An accepted command other than a no-op scans the cells, then, for a schedule of a
// real action kind, passes a write state; every command then passes a count state
// before res.valid rises. One item at a time: a new command is taken only after the
// last result word of the previous one is accepted. Reset (synchronous, rst high)
// clears all entries to inactive and released; no clearing pass is needed.
`include "assert_macros.svh"
module timed_action_scheduler #(
  parameter int NUM_ENTRIES = 8
) (
  input logic clk,
  input logic rst,
  tas_cmd_if.sink   cmd,
  tas_res_if.source res
);
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [2:0] state;
  tas_pkg::cmd_t c;
  logic [IW-1:0] idx;
  logic [1:0] pass;
  logic [3:0] lim;
  tas_pkg::tok_t tok;
  tas_pkg::tok_t tok_o [NUM_ENTRIES];
  tas_pkg::cell_rpt_t rpt [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] turn, sel;
  logic [IW-1:0] slot;
  logic have_slot, acc, keyact;
  logic [3:0] cnt;
  logic [1:0] ev_kind [tas_pkg::MAX_RESULTS];
  logic [7:0] ev_tgt [tas_pkg::MAX_RESULTS];
  logic       ev_pr [tas_pkg::MAX_RESULTS];
  logic [3:0] nout, oidx;
  logic last_cell;

  assign lim = (c.event_limit > 4'd8) ? 4'd8 : c.event_limit;
  assign last_cell = (idx == IW'(NUM_ENTRIES - 1));

  genvar g;
  generate
    for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
      assign turn[g] = (state == ST_SCAN || state == ST_WRITE) && idx == IW'(g);
      assign sel[g] = have_slot && slot == IW'(g);
      tas_cell u_cell (
        .clk(clk), .rst(rst), .turn(turn[g]),
        .pass((state == ST_WRITE) ? tas_pkg::PASS_WRITE : pass),
        .cmd(c), .lim(lim), .sel(sel[g]), .tok_in(tok),
        .tok_out(tok_o[g]), .rpt(rpt[g])
      );
    end
  endgenerate

  assign cmd.ready = (state == ST_IDLE);
  assign res.valid = (state == ST_OUT);
  always_comb begin
    res.data = '0;
    res.data.accepted = acc;
    res.data.active_entries = cnt;
    res.data.key_active = keyact;
    res.data.last = (nout == 4'd0) || (oidx + 4'd1 == nout);
    if (nout != 4'd0) begin
      res.data.event_valid = 1'b1;
      res.data.event_kind = ev_kind[oidx[2:0]];
      res.data.event_target = ev_tgt[oidx[2:0]];
      res.data.event_pressed = ev_pr[oidx[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      nout <= 4'd0;
      oidx <= 4'd0;
      tok <= '0;
      have_slot <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            c <= cmd.data;
            idx <= '0;
            tok <= '0;
            have_slot <= 1'b0;
            acc <= 1'b0;
            nout <= 4'd0;
            oidx <= 4'd0;
            pass <= (cmd.data.operation == tas_pkg::OP_CANCEL) ? tas_pkg::PASS_CANCEL :
                    (cmd.data.operation == tas_pkg::OP_TICK) ? tas_pkg::PASS_TICK :
                    tas_pkg::PASS_MATCH;
            state <= (cmd.data.operation == tas_pkg::OP_NONE) ? ST_COUNT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          tok <= tok_o[idx];
          if (rpt[idx].emit) begin
            ev_kind[tok.events[2:0]] <= rpt[idx].kind;
            ev_tgt[tok.events[2:0]] <= rpt[idx].target;
            ev_pr[tok.events[2:0]] <= rpt[idx].pressed;
          end
          if (pass == tas_pkg::PASS_MATCH) begin
            if (rpt[idx].match && !tok.found_match) begin
              slot <= idx;
              have_slot <= 1'b1;
            end else if (!rpt[idx].active && !tok.found_match && !tok.found_free
                         && !have_slot) begin
              slot <= idx;
              have_slot <= 1'b1;
            end
          end
          if (last_cell) begin
            idx <= '0;
            nout <= tok_o[idx].events;
            if (pass == tas_pkg::PASS_MATCH && c.action_kind != tas_pkg::KIND_NONE) begin
              state <= ST_WRITE;
            end else begin
              state <= ST_COUNT;
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        ST_WRITE: begin
          // The chosen cell writes in the cycle where the index reaches it.
          if (!have_slot || idx == slot) begin
            acc <= have_slot;
            idx <= '0;
            state <= ST_COUNT;
          end else begin
            idx <= slot;
          end
        end
        ST_COUNT: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (res.ready) begin
            if (nout == 4'd0 || oidx + 4'd1 == nout) begin
              state <= ST_IDLE;
            end else begin
              oidx <= oidx + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Active count and key lookup over the settled table.
  always_ff @(posedge clk) begin
    logic [7:0] n;
    logic k;
    n = '0;
    k = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      n = n + {7'd0, rpt[i].active};
      k = k | rpt[i].key_hit;
    end
    if (state == ST_COUNT) begin
      cnt <= (n > 8'd15) ? 4'd15 : n[3:0];
      keyact <= k;
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, cmd.ready, state == ST_IDLE)
  `ASSERT_IMPLIES(a_out_bound, clk, rst, res.valid, nout <= 4'd8)
  `ASSERT_NEXT(a_accept_busy, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
endmodule
